// File: sv/btgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btgm_pkg: shared types and constants of the battery gauge
// Field widths, register indexes, scaling constants, beat and divider structs.
// ----------------------------------------------------------------------------
package btgm_pkg;

  localparam int CODE_W     = 10;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int DB_W       = 8;
  localparam int FAC_W      = 5;
  localparam int SUM_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_N_W    = 24;
  localparam int DIV_D_W    = 16;
  localparam int DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd24;

  localparam logic [11:0]       FULL_SCALE_MV = 12'd3300;
  localparam logic [CODE_W-1:0] CODE_MAX      = 10'd1023;
  localparam logic [PCT_W-1:0]  PCT_MAX       = 7'd100;
  localparam logic [MV_W-1:0]   MV_MAX        = 16'hFFFF;

  // code * 3300 / 1023 as a reciprocal multiply: ceil(2^32 / 1023)
  localparam int MV_PROD_W = 22;
  localparam int MV_CODE_W = 12;
  localparam int MV_RCP_W  = 23;
  localparam int MV_RCP_SH = 32;
  localparam logic [MV_RCP_W-1:0] MV_RCP = 23'd4198405;

  localparam logic [MV_W-1:0]  EMPTY_MV_RST = 16'd3300;
  localparam logic [MV_W-1:0]  FULL_MV_RST  = 16'd4200;
  localparam logic [DB_W-1:0]  DEADBAND_RST = 8'd5;
  localparam logic [FAC_W-1:0] FACTOR_RST   = 5'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_EMPTY_MV  = 3'd0,
    CFG_FULL_MV   = 3'd1,
    CFG_DEADBAND  = 3'd2,
    CFG_FACTOR    = 3'd3,
    CFG_REPORT_EN = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] adc_sample;
    logic              usb_powered;
  } btgm_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] filtered_code;
    logic [MV_W-1:0]   battery_mv;
    logic [PCT_W-1:0]  percent;
    logic              report;
  } btgm_out_t;

  typedef struct packed {
    logic               valid;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: sv/btgm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btgm_div: restoring divider, one quotient bit per cycle
// Loads on req.valid, runs DIV_STEPS steps, pulses rsp.done with the quotient.
// ----------------------------------------------------------------------------
module btgm_div import btgm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dvsr;
  logic [DIV_N_W-1:0]   dvd;
  logic                 done;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  assign trial = {rem, dvd[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.valid) begin
        cnt  <= DIV_STEPS;
        rem  <= '0;
        dvsr <= req.divisor;
        dvd  <= req.dividend;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (fits) begin
          rem <= DIV_D_W'(trial - {1'b0, dvsr});
          dvd <= {dvd[DIV_N_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_D_W-1:0];
          dvd <= {dvd[DIV_N_W-2:0], 1'b0};
        end
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule
`default_nettype wire

// File: sv/battery_gauge_trimmed_mean_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_gauge_trimmed_mean_top: trimmed-mean battery gauge with deadband
//
// Input: one ADC beat (item) is taken on a clock edge with start high and busy
// low. Samples inside a burst give no result and leave busy low.
// The last sample of a burst of SAMPLES starts a short sequencer: trimmed
// average by reciprocal multiply, deadband, code to millivolts, divider
// factor, then millivolts to percent on a restoring divider (one quotient
// bit per cycle, 24 steps). Busy stays high through the sequencer and the
// divider; the divider is skipped when the percent needs no division (USB
// power, or voltage at or outside the empty..full bounds).
// Output: result is valid for exactly one cycle with done high, the first
// cycle with busy low again; the receiver cannot stall it.
// Config: cfg_we writes cfg_wdata to register cfg_addr; write
// only while busy is low. Unused indexes are ignored.
// Reset (rst, synchronous): registers take their defaults, the held code
// and the burst accumulators clear.
// ----------------------------------------------------------------------------
module battery_gauge_trimmed_mean_top import btgm_pkg::*; #(
  parameter int SAMPLES = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  btgm_in_t              item,
  output logic                  done,
  output btgm_out_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(SAMPLES);
  localparam logic [CNT_W:0]     LAST_CNT = (CNT_W+1)'(SAMPLES);
  // trimmed sum / (SAMPLES-2) as a reciprocal multiply, exact for 16-bit sums
  localparam int AVG_D  = SAMPLES - 2;
  localparam int AVG_SH = SUM_W + $clog2(AVG_D);
  localparam logic [SUM_W:0] AVG_RCP =
    (SUM_W+1)'(((64'd1 << AVG_SH) + 64'(AVG_D) - 64'd1) / 64'(AVG_D));

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_AVG   = 9'b0_0000_0010,
    S_HOLD  = 9'b0_0000_0100,
    S_PROD  = 9'b0_0000_1000,
    S_MV    = 9'b0_0001_0000,
    S_SCALE = 9'b0_0010_0000,
    S_PCT   = 9'b0_0100_0000,
    S_PCT_W = 9'b0_1000_0000,
    S_OUT   = 9'b1_0000_0000
  } state_t;

  state_t state;

  logic [MV_W-1:0]   empty_mv;
  logic [MV_W-1:0]   full_mv;
  logic [DB_W-1:0]   deadband;
  logic [FAC_W-1:0]  factor;
  logic              report_en;

  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [CODE_W-1:0] largest;
  logic [CODE_W-1:0] smallest;
  logic [CODE_W-1:0] held;
  logic [CODE_W-1:0] avg;
  logic [MV_PROD_W-1:0] prod;
  logic [MV_CODE_W-1:0] code_mv;
  logic [MV_W-1:0]   mv;
  logic [PCT_W-1:0]  pct;
  logic              usb;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              accept;
  logic              last;
  logic [SUM_W-1:0]  trim;
  logic [2*SUM_W:0]  avg_prod;
  logic [CODE_W-1:0] avg_code;
  logic [MV_PROD_W-1:0] code_prod;
  logic [MV_PROD_W+MV_RCP_W-1:0] rcp_prod;
  logic [22:0]       pct_prod;
  logic [MV_W-1:0]   span;
  logic              pct_div;
  logic signed [11:0] avg_s;
  logic signed [11:0] hi_s;
  logic signed [11:0] lo_s;
  logic              move;
  logic [16:0]       scaled;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;
  assign last   = ({1'b0, count} + 1'b1) >= LAST_CNT;

  assign trim     = sum - SUM_W'(largest) - SUM_W'(smallest);
  assign avg_prod = {{(SUM_W+1){1'b0}}, trim} * {{SUM_W{1'b0}}, AVG_RCP};
  assign avg_code = CODE_W'(avg_prod >> AVG_SH);

  assign code_prod = {12'b0, held} * {10'b0, FULL_SCALE_MV};
  assign rcp_prod  = {{MV_RCP_W{1'b0}}, prod} * {{MV_PROD_W{1'b0}}, MV_RCP};
  assign scaled    = {5'b0, code_mv} * {12'b0, factor};

  assign pct_prod  = {7'b0, MV_W'(mv - empty_mv)} * {16'b0, PCT_MAX};
  assign span      = full_mv - empty_mv;
  assign pct_div   = !usb && (mv < full_mv) && (mv > empty_mv);

  assign avg_s = $signed({2'b00, avg});
  assign hi_s  = $signed({2'b00, held}) + $signed({4'b0000, deadband});
  assign lo_s  = $signed({2'b00, held}) - $signed({4'b0000, deadband});
  assign move  = (avg_s > hi_s) || (avg_s < lo_s);

  always_comb begin
    div_req = '0;
    case (state)
      S_PCT: begin
        div_req.valid    = pct_div;
        div_req.dividend = DIV_N_W'(pct_prod);
        div_req.divisor  = span;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  btgm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      empty_mv  <= EMPTY_MV_RST;
      full_mv   <= FULL_MV_RST;
      deadband  <= DEADBAND_RST;
      factor    <= FACTOR_RST;
      report_en <= 1'b0;
      count     <= '0;
      sum       <= '0;
      largest   <= '0;
      smallest  <= CODE_MAX;
      held      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_EMPTY_MV:  empty_mv  <= cfg_wdata;
          CFG_FULL_MV:   full_mv   <= cfg_wdata;
          CFG_DEADBAND:  deadband  <= cfg_wdata[DB_W-1:0];
          CFG_FACTOR:    factor    <= cfg_wdata[FAC_W-1:0];
          CFG_REPORT_EN: report_en <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sum <= sum + SUM_W'(item.adc_sample);
            if (item.adc_sample > largest) largest <= item.adc_sample;
            if (item.adc_sample < smallest) smallest <= item.adc_sample;
            usb <= item.usb_powered;
            if (last) begin
              state <= S_AVG;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        S_AVG: begin
          avg   <= avg_code;
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (move) held <= avg;
          state <= S_PROD;
        end
        S_PROD: begin
          prod  <= code_prod;
          state <= S_MV;
        end
        S_MV: begin
          code_mv <= rcp_prod[MV_RCP_SH +: MV_CODE_W];
          state   <= S_SCALE;
        end
        S_SCALE: begin
          mv    <= scaled[16] ? MV_MAX : scaled[MV_W-1:0];
          state <= S_PCT;
        end
        S_PCT: begin
          if (pct_div) begin
            state <= S_PCT_W;
          end else begin
            pct   <= (usb || mv >= full_mv) ? PCT_MAX : '0;
            state <= S_OUT;
          end
        end
        S_PCT_W: begin
          if (div_rsp.done) begin
            pct   <= div_rsp.quotient[PCT_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done                 <= 1'b1;
          result.filtered_code <= held;
          result.battery_mv    <= mv;
          result.percent       <= pct;
          result.report        <= report_en && !usb;
          count                <= '0;
          sum                  <= '0;
          largest              <= '0;
          smallest             <= CODE_MAX;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/btgm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btgm_checker: port-level checks of the battery gauge
// Result strobe timing against the command side, and percent range.
// ----------------------------------------------------------------------------
module btgm_checker import btgm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input btgm_out_t result
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one beat");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.percent <= PCT_MAX))
    else $error("percent above full scale");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result right after an accepted beat");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

endmodule

bind battery_gauge_trimmed_mean_top btgm_checker u_btgm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
